FILE: sv/smpd_pkg.sv
`default_nettype none
package smpd_pkg;

	localparam int MARKER_BYTES = 16;
	localparam int MK_IDX_W     = (MARKER_BYTES > 1) ? $clog2(MARKER_BYTES) : 1;

	localparam logic [31:0] LEN_FIRST      = 32'd36;
	localparam logic [31:0] LEN_LAST       = 32'd39;
	localparam logic [31:0] MIN_PACKET_LEN = 32'd60;
	localparam logic [31:0] MAX_LEN_RESET  = 32'd65536;

	localparam int CMDQ_DEPTH = 32;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	typedef enum logic {
		CMD_BYTE,
		CMD_MARKER
	} cmd_kind_t;

	typedef enum logic {
		FS_HUNT,
		FS_PACKET
	} front_state_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic        err;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        err;
	} out_item_t;

	// marker string followed by zero bytes
	function automatic logic [7:0] marker_byte(input logic [4:0] i);
		logic [7:0] b;
		case (i)
			5'd0:    b = 8'h53;
			5'd1:    b = 8'h54;
			5'd2:    b = 8'h52;
			5'd3:    b = 8'h45;
			5'd4:    b = 8'h41;
			5'd5:    b = 8'h4D;
			5'd6:    b = 8'h70;
			5'd7:    b = 8'h61;
			5'd8:    b = 8'h63;
			5'd9:    b = 8'h6B;
			5'd10:   b = 8'h49;
			5'd11:   b = 8'h44;
			5'd12:   b = 8'h76;
			5'd13:   b = 8'h31;
			5'd14:   b = 8'h2E;
			5'd15:   b = 8'h30;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

FILE: sv/smpd_front.sv
`default_nettype none
module smpd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [7:0]     in_byte,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_data,
	output smpd_pkg::cmd_t      cmd,
	output logic                cmd_push
);

	smpd_pkg::front_state_t state_q, state_d;
	logic [7:0]  window_q [smpd_pkg::MARKER_BYTES];
	logic [7:0]  win_shift [smpd_pkg::MARKER_BYTES];
	logic [31:0] idx_q, idx_d;
	logic [31:0] dlen_q, dlen_d, dlen_new;
	logic [31:0] max_len_q;
	logic        match;
	logic        clear_win;
	logic        shift_win;
	logic        last, err;

	always_comb begin
		for (int k = 0; k < smpd_pkg::MARKER_BYTES - 1; k++) begin
			win_shift[k] = window_q[k + 1];
		end
		win_shift[smpd_pkg::MARKER_BYTES - 1] = in_byte;
		match = 1'b1;
		for (int k = 0; k < smpd_pkg::MARKER_BYTES; k++) begin
			if (win_shift[k] != smpd_pkg::marker_byte(5'(k))) match = 1'b0;
		end
	end

	// merge the length byte at offsets 36..39, little-endian
	always_comb begin
		if (idx_q inside {[smpd_pkg::LEN_FIRST:smpd_pkg::LEN_LAST]}) begin
			dlen_new = dlen_q | ({24'd0, in_byte} << {idx_q[1:0], 3'b000});
		end else begin
			dlen_new = dlen_q;
		end
		err  = (idx_q == smpd_pkg::LEN_LAST) &&
		       ((dlen_new < smpd_pkg::MIN_PACKET_LEN) || (dlen_new > max_len_q));
		last = err || ((idx_q >= smpd_pkg::LEN_LAST) && ((idx_q + 32'd1) >= dlen_new));
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		dlen_d    = dlen_q;
		cmd_push  = 1'b0;
		clear_win = 1'b0;
		shift_win = 1'b0;
		cmd.kind  = smpd_pkg::CMD_BYTE;
		cmd.data  = in_byte;
		cmd.last  = last;
		cmd.err   = err;
		case (state_q)
			smpd_pkg::FS_HUNT: begin
				cmd.kind = smpd_pkg::CMD_MARKER;
				if (in_valid) begin
					if (match) begin
						cmd_push  = 1'b1;
						clear_win = 1'b1;
						state_d   = smpd_pkg::FS_PACKET;
						idx_d     = 32'(smpd_pkg::MARKER_BYTES);
						dlen_d    = 32'd0;
					end else begin
						shift_win = 1'b1;
					end
				end
			end
			smpd_pkg::FS_PACKET: begin
				if (in_valid) begin
					cmd_push = 1'b1;
					dlen_d   = dlen_new;
					if (last) begin
						state_d = smpd_pkg::FS_HUNT;
						idx_d   = 32'd0;
					end else begin
						idx_d   = idx_q + 32'd1;
					end
				end
			end
			default: begin
				state_d = smpd_pkg::FS_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= smpd_pkg::FS_HUNT;
			idx_q     <= 32'd0;
			dlen_q    <= 32'd0;
			max_len_q <= smpd_pkg::MAX_LEN_RESET;
			for (int k = 0; k < smpd_pkg::MARKER_BYTES; k++) window_q[k] <= 8'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			dlen_q  <= dlen_d;
			if (cfg_we) max_len_q <= cfg_data;
			if (clear_win) begin
				for (int k = 0; k < smpd_pkg::MARKER_BYTES; k++) window_q[k] <= 8'd0;
			end else if (shift_win) begin
				for (int k = 0; k < smpd_pkg::MARKER_BYTES; k++) window_q[k] <= win_shift[k];
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/smpd_cmd_fifo.sv
`default_nettype none
module smpd_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  smpd_pkg::cmd_t      wr_cmd,
	output logic                full,
	input  wire logic           rd_en,
	output smpd_pkg::cmd_t      rd_cmd,
	output logic                not_empty
);

	smpd_pkg::cmd_t               mem_q [smpd_pkg::CMDQ_DEPTH];
	logic [smpd_pkg::CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [smpd_pkg::CMDQ_AW:0]   count_q;
	logic                         do_wr, do_rd;

	assign full      = (count_q == (smpd_pkg::CMDQ_AW + 1)'(smpd_pkg::CMDQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/smpd_back.sv
`default_nettype none
module smpd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  smpd_pkg::cmd_t      cmd,
	input  wire logic           cmd_avail,
	output logic                cmd_pop,
	output smpd_pkg::out_item_t item,
	output logic                item_valid,
	input  wire logic           item_take
);

	logic [smpd_pkg::MK_IDX_W-1:0] cnt_q;
	logic                          out_valid_q;
	smpd_pkg::out_item_t           out_q, next_item;
	logic                          load;
	logic                          burst_end;

	assign load      = cmd_avail && (!out_valid_q || item_take);
	assign burst_end = (cnt_q == smpd_pkg::MK_IDX_W'(smpd_pkg::MARKER_BYTES - 1));

	always_comb begin
		if (cmd.kind == smpd_pkg::CMD_MARKER) begin
			next_item.data = smpd_pkg::marker_byte(5'(cnt_q));
			next_item.last = 1'b0;
			next_item.err  = 1'b0;
			cmd_pop        = load && burst_end;
		end else begin
			next_item.data = cmd.data;
			next_item.last = cmd.last;
			next_item.err  = cmd.err;
			cmd_pop        = load;
		end
	end

	assign item       = out_q;
	assign item_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (load) out_q <= next_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (item_take) out_valid_q <= 1'b0;
			if (load && cmd.kind == smpd_pkg::CMD_MARKER) begin
				cnt_q <= burst_end ? '0 : cnt_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/sync_marker_packet_deframer.sv
`default_nettype none
// Channel   | Direction | Handshake            | Payload
// input     | in        | push / full          | data_byte[7:0]
// result    | out       | pop / empty          | out_byte[7:0], packet_last, length_error
// config    | in        | cfg_valid / cfg_ready| cfg_data[31:0] (max_packet_len)
//
// One byte is accepted per cycle unless full; the front classifies it in that cycle.
// A marker hit expands into 16 result items in the back, one per cycle unless the result side stalls;
// a 32-entry command queue absorbs the burst so input keeps flowing.
// A result passes through the command queue and the output register to the result ports.
// Reset (arst_n low) returns to hunting with a zero window, max length 65536.
// Either side may stall independently; full rises only when the queue fills.
module sync_marker_packet_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             packet_last,
	output logic             length_error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	smpd_pkg::cmd_t      front_cmd, head_cmd;
	smpd_pkg::out_item_t item;
	logic                front_push;
	logic                q_full, q_avail, q_pop;
	logic                item_valid;
	logic                accept;

	// the user must write the register only while idle; the block does not enforce this, cfg_ready stays high
	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	// front: marker hunt, offset tracking, length check
	smpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_byte  (data_byte),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (front_cmd),
		.cmd_push (front_push)
	);

	// decouple the front from the burst expansion
	smpd_cmd_fifo u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (front_push),
		.wr_cmd    (front_cmd),
		.full      (q_full),
		.rd_en     (q_pop),
		.rd_cmd    (head_cmd),
		.not_empty (q_avail)
	);

	// back: expand marker bursts, hold the result in the output register
	smpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (head_cmd),
		.cmd_avail  (q_avail),
		.cmd_pop    (q_pop),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (pop)
	);

	assign empty        = !item_valid;
	assign out_byte     = item.data;
	assign packet_last  = item.last;
	assign length_error = item.err;

endmodule
`default_nettype wire

FILE: sv/smpd_checker.sv
`default_nettype none
module smpd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] out_byte,
	input wire logic       packet_last,
	input wire logic       length_error
);

	// an aborted packet always ends on the flagged item
	a_err_ends_packet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && length_error |-> packet_last)
		else $error("length_error without packet_last");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable({out_byte, packet_last, length_error}))
		else $error("result item changed while stalled");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result shown right after reset");

endmodule

bind sync_marker_packet_deframer smpd_checker u_smpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.out_byte     (out_byte),
	.packet_last  (packet_last),
	.length_error (length_error)
);
`default_nettype wire
